### rtl/core/eight_channel_button_debouncer_assert.svh
// assertion macros used by the debouncer checker
`ifndef EIGHT_CHANNEL_BUTTON_DEBOUNCER_ASSERT_SVH
`define EIGHT_CHANNEL_BUTTON_DEBOUNCER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define ECBD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("debouncer check failed");

// next-cycle implication, disabled while in reset
`define ECBD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("debouncer check failed");

`endif

### rtl/core/ecbd_pkg.sv
// ----------------------------------------------------------------------------
// ecbd_pkg
// shared types and constants of the eight channel button debouncer
// ----------------------------------------------------------------------------
package ecbd_pkg;

    localparam int FIELD_W = 8;
    localparam int CFG_W   = 8;
    localparam int APB_W   = 32;
    localparam int ADDR_W  = 3;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 8'd10;

    typedef enum logic
    {
        REG_SWITCH_MASK = 1'b0,
        REG_DEBOUNCE    = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic [FIELD_W-1:0] pin_levels;
        logic               scan_enable;
    } sample_t;

    typedef struct packed
    {
        logic [FIELD_W-1:0] latch_value;
        logic [FIELD_W-1:0] settled_channels;
    } result_t;

    typedef struct packed
    {
        logic fire;
        logic scan;
        logic sel;
    } lane_ctrl_t;

endpackage

### rtl/core/eight_channel_button_debouncer.sv
// ----------------------------------------------------------------------------
// eight_channel_button_debouncer
// counter style switch debouncer for up to eight pins
// ----------------------------------------------------------------------------
// sample channel (valid/stall, struct sample) carries one tick: pin levels and
// a scan enable. result channel (valid/stall, struct result) returns exactly
// one item per tick: the latch after that tick, a set bit meaning the pin
// settled low, and the channels that reached the threshold on that tick.
// an item is held in the input register and then computed into the result
// register, a step that waits while a stalled result occupies it. one item
// is accepted per cycle while sample_stall is low; all channel counters
// update in parallel in the step from input register to result register.
// while the result receiver stalls, the waiting result holds and one more
// item can still be taken into the input register; after that sample_stall
// rises until the result is taken. reset clears counters, previous levels,
// latch and both stages, sets switch_mask to 0 and debounce_ticks to 10.
// registers are written over the apb port (switch_mask at 0x0,
// debounce_ticks at 0x4); the user writes them only while the block idles,
// which the block itself does not enforce.
// ----------------------------------------------------------------------------
module eight_channel_button_debouncer #(
    parameter int CHANNELS   = 8,
    parameter int COUNT_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ecbd_pkg::ADDR_W-1:0] paddr,
    input  logic [ecbd_pkg::APB_W-1:0]  pwdata,
    output logic [ecbd_pkg::APB_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        sample_valid,
    output logic                        sample_stall,
    input  ecbd_pkg::sample_t           sample,
    output logic                        result_valid,
    input  logic                        result_stall,
    output ecbd_pkg::result_t           result
);
    import ecbd_pkg::*;

    // only the low eight channels reach the fields
    localparam int ACTIVE = (CHANNELS < FIELD_W) ? CHANNELS : FIELD_W;

    logic [CFG_W-1:0] mask_reg;
    logic [CFG_W-1:0] thresh_reg;
    reg_index_t       reg_sel;
    logic             cfg_write;

    logic    s1_valid_reg;
    logic    s1_valid_next;
    sample_t s1_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;
    result_t out_next;

    logic out_free;
    logic s1_fire;
    logic sample_acc;

    logic [ACTIVE-1:0] lane_latch;
    logic [ACTIVE-1:0] lane_settled;

    // configuration port
    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_sel)
            REG_SWITCH_MASK: prdata = APB_W'(mask_reg);
            REG_DEBOUNCE:    prdata = APB_W'(thresh_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= '0;
            thresh_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_SWITCH_MASK: mask_reg   <= pwdata[CFG_W-1:0];
                REG_DEBOUNCE:    thresh_reg <= pwdata[CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    // two-stage flow control
    assign out_free      = !out_valid_reg || !result_stall;
    assign s1_fire       = s1_valid_reg && out_free;
    assign sample_stall  = s1_valid_reg && !out_free;
    assign sample_acc    = sample_valid && !sample_stall;
    assign s1_valid_next = sample_acc ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_fire ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);

    genvar n;
    generate
        for (n = 0; n < ACTIVE; n++)
        begin : g_lane
            lane_ctrl_t ctrl;
            assign ctrl.fire = s1_fire;
            assign ctrl.scan = s1_reg.scan_enable;
            assign ctrl.sel  = mask_reg[n];

            ecbd_lane #(
                .COUNT_BITS (COUNT_BITS)
            ) u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .pin       (s1_reg.pin_levels[n]),
                .threshold (thresh_reg),
                .latch_new (lane_latch[n]),
                .settled   (lane_settled[n])
            );
        end
    endgenerate

    assign out_next.latch_value      = FIELD_W'(lane_latch);
    assign out_next.settled_channels = FIELD_W'(lane_settled);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            s1_reg <= sample;
        end
        if (s1_fire)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### rtl/core/ecbd_lane.sv
// ----------------------------------------------------------------------------
// ecbd_lane
// one channel: previous level, saturating streak counter and latch bit
// ----------------------------------------------------------------------------
module ecbd_lane #(
    parameter int COUNT_BITS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ecbd_pkg::lane_ctrl_t       ctrl,
    input  logic                       pin,
    input  logic [ecbd_pkg::CFG_W-1:0] threshold,
    output logic                       latch_new,
    output logic                       settled
);
    import ecbd_pkg::*;

    localparam int CW = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic                  prev_reg;
    logic                  prev_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  latch_reg;
    logic                  latch_next;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  same;
    logic                  hit;

    assign same      = (pin == prev_reg);
    assign count_inc = (count_reg == CNT_MAX) ? CNT_MAX : count_reg + 1'b1;
    // settle only on the tick the counter changes to the threshold
    assign hit       = (count_reg != CNT_MAX) && (CW'(count_inc) == CW'(threshold));

    always_comb
    begin
        prev_next  = prev_reg;
        count_next = count_reg;
        latch_next = latch_reg;
        settled    = 1'b0;
        if (!ctrl.scan)
        begin
            prev_next = 1'b0;
        end
        else if (ctrl.sel)
        begin
            if (same)
            begin
                count_next = count_inc;
                if (hit)
                begin
                    latch_next = ~pin;
                    settled    = 1'b1;
                end
            end
            else
            begin
                prev_next  = pin;
                count_next = '0;
            end
        end
    end

    assign latch_new = latch_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 1'b0;
            count_reg <= '0;
            latch_reg <= 1'b0;
        end
        else if (ctrl.fire)
        begin
            prev_reg  <= prev_next;
            count_reg <= count_next;
            latch_reg <= latch_next;
        end
    end

endmodule

### rtl/core/ecbd_checker.sv
// ----------------------------------------------------------------------------
// ecbd_checker
// port-level checks of the debouncer, bound to the top level
// ----------------------------------------------------------------------------
`include "eight_channel_button_debouncer_assert.svh"

module ecbd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              sample_valid,
    input logic              sample_stall,
    input logic              result_valid,
    input logic              result_stall,
    input ecbd_pkg::result_t result
);
    import ecbd_pkg::*;

    logic               in_acc;
    logic               out_acc;
    logic [1:0]         pending_reg;
    logic [1:0]         pending_next;
    logic [FIELD_W-1:0] last_latch_reg;

    assign in_acc       = sample_valid && !sample_stall;
    assign out_acc      = result_valid && !result_stall;
    assign pending_next = pending_reg + 2'(in_acc) - 2'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            last_latch_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (out_acc)
            begin
                last_latch_reg <= result.latch_value;
            end
        end
    end

    // a stalled result holds
    `ECBD_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(result))
    // latch bits move only where a channel settled
    `ECBD_ASSERT_NOW(a_latch_moves_on_settle, result_valid,
        ((result.latch_value ^ last_latch_reg) & ~result.settled_channels) == '0)
    // no result without an item taken for it
    `ECBD_ASSERT_NOW(a_no_spurious_result, result_valid, pending_reg != 2'd0)
    // at most two items in flight
    `ECBD_ASSERT_NOW(a_depth, 1'b1, pending_reg != 2'd3)

endmodule

bind eight_channel_button_debouncer ecbd_checker u_ecbd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
